// ----- hdl/address_resolution_table_unit_assert.svh -----
// Assertion macros shared by the address resolution table unit.
`ifndef ADDRESS_RESOLUTION_TABLE_UNIT_ASSERT_SVH
`define ADDRESS_RESOLUTION_TABLE_UNIT_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ARAT_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("address resolution table check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define ARAT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("address resolution table check failed");

`endif

// ----- hdl/arat_pkg.sv -----
// Shared constants and types of the address resolution table.
package arat_pkg;

   localparam int ENTRIES  = 16;
   localparam int CNT_W    = $clog2(ENTRIES + 1);
   localparam int CMD_W    = 2;
   localparam int NODE_W   = 8;
   localparam int HW_W     = 48;
   localparam int IFACE_W  = 8;
   localparam int STATUS_W = 3;
   localparam int FILL_W   = 5;

   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

   localparam logic [IFACE_W-1:0] NO_IFACE = 8'hFF;

   // Search token passed from cell to cell along the chain.
   typedef struct packed {
      logic               active;
      logic [NODE_W-1:0]  key;
      logic               hit;
      logic [HW_W-1:0]    hw_addr;
      logic [IFACE_W-1:0] iface;
   } link_type;

endpackage

// ----- hdl/arat_cell.sv -----
// One table entry with its stage of the search chain.
module arat_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [arat_pkg::NODE_W-1:0]  wr_node_addr,
   input  logic [arat_pkg::HW_W-1:0]    wr_hw_addr,
   input  logic [arat_pkg::IFACE_W-1:0] wr_iface,
   input  logic                         filled,
   input  arat_pkg::link_type           link_in,
   output arat_pkg::link_type           link_out
);
   import arat_pkg::*;

   logic [NODE_W-1:0]  node_ff;
   logic [HW_W-1:0]    hw_ff;
   logic [IFACE_W-1:0] iface_ff;
   link_type           link_ff;
   link_type           link_in_next;
   logic               match;

   // Store the entry on insert
   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_ff  <= wr_node_addr;
         hw_ff    <= wr_hw_addr;
         iface_ff <= wr_iface;
      end
   end

   // Claim the token on the first match of a filled entry
   always_comb begin
      match        = link_in.active && filled && !link_in.hit && (node_ff == link_in.key);
      link_in_next = link_in;
      if (match) begin
         link_in_next.hit     = 1'b1;
         link_in_next.hw_addr = hw_ff;
         link_in_next.iface   = iface_ff;
      end
   end

   // Advance the token to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= '0;
      end else begin
         link_ff <= link_in_next;
      end
   end

   assign link_out = link_ff;

endmodule

// ----- hdl/address_resolution_table_unit.sv -----
// Top level of the address resolution table: control, cell chain, result register.
//
// Usage: a request transaction on req_* carries a command (lookup, insert,
// clear), a node address and, for inserts, a hardware address and interface.
// Every request yields exactly one response transaction on rsp_* with a
// status, the matching hardware address and interface (zero and 255 when
// there is none) and the table fill level after the operation.
// One request is worked on at a time; req_stall is high while it is busy.
// Insert and clear go from acceptance to S_FINISH, which loads the response
// register once it is free and returns to idle for the next request. A
// lookup sends a search token down the chain of ENTRIES cells, one cell per
// cycle; S_SCAN waits for it at the chain's end, then S_FINISH goes on alike.
// The response register parts the two sides: a new request is accepted while
// a finished response still waits under rsp_stall. A further finished result
// waits inside until the response register is free.
// Reset empties the table (fill level zero) and drops any pending response.
module address_resolution_table_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [arat_pkg::CMD_W-1:0]    req_cmd,
   input  logic [arat_pkg::NODE_W-1:0]   req_node_addr,
   input  logic [arat_pkg::HW_W-1:0]     req_hw_addr_in,
   input  logic [arat_pkg::IFACE_W-1:0]  req_iface_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [arat_pkg::STATUS_W-1:0] rsp_status,
   output logic [arat_pkg::HW_W-1:0]     rsp_hw_addr_out,
   output logic [arat_pkg::IFACE_W-1:0]  rsp_iface_out,
   output logic [arat_pkg::FILL_W-1:0]   rsp_fill_level
);
   import arat_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     fill_count_ff, fill_count_in;
   logic [STATUS_W-1:0]  pend_status_ff, pend_status_in;
   logic [HW_W-1:0]      pend_hw_ff, pend_hw_in;
   logic [IFACE_W-1:0]   pend_iface_ff, pend_iface_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [HW_W-1:0]      rsp_hw_ff, rsp_hw_in;
   logic [IFACE_W-1:0]   rsp_iface_ff, rsp_iface_in;
   logic [FILL_W-1:0]    rsp_fill_ff, rsp_fill_in;

   logic                 req_accept;
   logic                 is_insert;
   logic                 is_clear;
   logic                 is_lookup;
   logic                 table_full;
   logic                 insert_ok;
   logic                 rsp_free;
   link_type             link [ENTRIES+1];

   // Decode the request
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign is_insert  = (req_cmd == CMD_INSERT);
   assign is_clear   = (req_cmd == CMD_CLEAR);
   assign is_lookup  = !is_insert && !is_clear;
   assign table_full = (fill_count_ff == CNT_W'(ENTRIES));
   assign insert_ok  = req_accept && is_insert && !table_full;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Launch the search token into the first cell
   always_comb begin
      link[0]         = '0;
      link[0].active  = req_accept && is_lookup;
      link[0].key     = req_node_addr;
      link[0].iface   = NO_IFACE;
   end

   // Build the chain of entry cells
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      arat_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .wr_en        (insert_ok && (fill_count_ff == CNT_W'(i))),
         .wr_node_addr (req_node_addr),
         .wr_hw_addr   (req_hw_addr_in),
         .wr_iface     (req_iface_in),
         .filled       (CNT_W'(i) < fill_count_ff),
         .link_in      (link[i]),
         .link_out     (link[i+1])
      );
   end

   // Sequence one transaction at a time
   always_comb begin
      state_in       = state_ff;
      fill_count_in  = fill_count_ff;
      pend_status_in = pend_status_ff;
      pend_hw_in     = pend_hw_ff;
      pend_iface_in  = pend_iface_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_hw_in      = rsp_hw_ff;
      rsp_iface_in   = rsp_iface_ff;
      rsp_fill_in    = rsp_fill_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               pend_hw_in    = '0;
               pend_iface_in = NO_IFACE;
               if (is_insert) begin
                  pend_status_in = table_full ? ST_DROPPED : ST_INSERTED;
                  if (!table_full) begin
                     fill_count_in = fill_count_ff + CNT_W'(1);
                  end
                  state_in = S_FINISH;
               end else if (is_clear) begin
                  pend_status_in = ST_CLEARED;
                  fill_count_in  = '0;
                  state_in       = S_FINISH;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (link[ENTRIES].active) begin
               pend_status_in = link[ENTRIES].hit ? ST_HIT : ST_MISS;
               pend_hw_in     = link[ENTRIES].hw_addr;
               pend_iface_in  = link[ENTRIES].iface;
               state_in       = S_FINISH;
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_hw_in     = pend_hw_ff;
               rsp_iface_in  = pend_iface_ff;
               rsp_fill_in   = FILL_W'(fill_count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_count_ff <= fill_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Hold pending and response payload
   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      pend_hw_ff     <= pend_hw_in;
      pend_iface_ff  <= pend_iface_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_hw_ff      <= rsp_hw_in;
      rsp_iface_ff   <= rsp_iface_in;
      rsp_fill_ff    <= rsp_fill_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_hw_addr_out = rsp_hw_ff;
   assign rsp_iface_out   = rsp_iface_ff;
   assign rsp_fill_level  = rsp_fill_ff;

   `include "address_resolution_table_unit_assert.svh"

   `ARAT_ASSERT_NOW(a_fill_bound, 1'b1, fill_count_ff <= CNT_W'(ENTRIES))
   `ARAT_ASSERT_NOW(a_token_in_scan, link[ENTRIES].active, state_ff == S_SCAN)
   `ARAT_ASSERT_NEXT(a_insert_grows, insert_ok, fill_count_ff == $past(fill_count_ff) + CNT_W'(1))

endmodule
